// ===== src/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
// Used by every module of the block; depends on nothing.
package ole_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int ST_W     = 3;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_BACK  = 3'd4,
        OP_SEARCH    = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     live;
    } t_cell_ctl;

endpackage

// ===== src/ole_cell.sv =====
// One cell of the list chain: holds one entry and compares it with the key.
// Depends on ole_pkg.
module ole_cell (
    input  logic                           i_clk,
    input  ole_pkg::t_cell_ctl             i_ctl,
    input  logic [ole_pkg::DATA_W-1:0]     i_new,
    input  logic [ole_pkg::DATA_W-1:0]     i_left,
    input  logic [ole_pkg::DATA_W-1:0]     i_right,
    input  logic [ole_pkg::DATA_W-1:0]     i_key,
    output logic [ole_pkg::DATA_W-1:0]     o_value,
    output logic                           o_match
);

    logic [ole_pkg::DATA_W-1:0] r_value;
    logic [ole_pkg::DATA_W-1:0] n_value;

    always_comb begin
        unique case (i_ctl.op)
            ole_pkg::CELL_HOLD:       n_value = r_value;
            ole_pkg::CELL_LOAD:       n_value = i_new;
            ole_pkg::CELL_FROM_LEFT:  n_value = i_left;
            ole_pkg::CELL_FROM_RIGHT: n_value = i_right;
            default:                  n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_match = i_ctl.live && (r_value == i_key);

endmodule

// ===== src/ole_first_match.sv =====
// Finds the lowest cell that reports a match.
// Depends on ole_pkg.
module ole_first_match (
    input  logic [ole_pkg::CAPACITY-1:0] i_match,
    output logic                         o_any,
    output logic [ole_pkg::IDX_W-1:0]    o_index
);

    logic [ole_pkg::CAPACITY-1:0] lowest;

    // Isolate the lowest set bit, then OR-encode its index.
    assign lowest = i_match & (~i_match + ole_pkg::CAPACITY'(1));
    assign o_any  = |i_match;

    always_comb begin
        o_index = '0;
        for (int j = 0; j < ole_pkg::CAPACITY; j++) begin
            if (lowest[j]) begin
                o_index = o_index | ole_pkg::IDX_W'(j);
            end
        end
    end

endmodule

// ===== src/ordered_list_engine.sv =====
// Ordered list engine, top level: a chain of cells, the count and the result register.
// Depends on ole_pkg, ole_cell and ole_first_match.
//
// Usage:
//   Requests arrive on i_valid/o_ready with i_op, i_value and i_position.
//   Each item gives exactly one result on o_valid/i_ready with o_status,
//   o_found_position and o_count (the count after the request).
//   The cell chain shifts and all cells compare in the cycle of acceptance,
//   and the result is registered at that edge. Throughput is one item per
//   cycle while the receiver keeps up; every cell updates at the same edge
//   whatever the position, so no op takes longer than another.
//   When the receiver stalls, the result stays in the output register and
//   o_ready drops until it is taken; an item is accepted in the same cycle
//   that the waiting result leaves.
//   Reset (i_rst_n low, synchronous) empties the list and drops o_valid.
//   Cell contents are not cleared; cells at or above the count are never
//   read.
module ordered_list_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [ole_pkg::OP_W-1:0]       i_op,
    input  logic signed [ole_pkg::DATA_W-1:0] i_value,
    input  logic [ole_pkg::POS_W-1:0]      i_position,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ole_pkg::ST_W-1:0]       o_status,
    output logic [ole_pkg::POS_W-1:0]      o_found_position,
    output logic [ole_pkg::POS_W-1:0]      o_count
);

    logic                         acc;
    logic                         is_full;
    logic                         is_empty;
    logic                         pos_ok;
    logic                         do_ins;
    logic                         do_rem_front;
    logic [ole_pkg::COUNT_W-1:0]  ins_idx;
    logic                         r_out_valid;
    logic [ole_pkg::ST_W-1:0]     r_status;
    logic [ole_pkg::ST_W-1:0]     n_status;
    logic [ole_pkg::POS_W-1:0]    r_found;
    logic [ole_pkg::POS_W-1:0]    n_found;
    logic [ole_pkg::COUNT_W-1:0]  r_count;
    logic [ole_pkg::COUNT_W-1:0]  n_count;
    logic [ole_pkg::POS_W-1:0]    r_count_out;
    logic [ole_pkg::CAPACITY-1:0] match;
    logic                         any_match;
    logic [ole_pkg::IDX_W-1:0]    match_idx;
    logic [ole_pkg::DATA_W-1:0]   cell_val [ole_pkg::CAPACITY];
    ole_pkg::t_cell_ctl           cell_ctl [ole_pkg::CAPACITY];

    assign o_ready  = !r_out_valid || i_ready;
    assign acc      = i_valid && o_ready;
    assign is_full  = (r_count == ole_pkg::COUNT_W'(ole_pkg::CAPACITY));
    assign is_empty = (r_count == '0);
    assign pos_ok   = (i_position != '0) &&
                      ((ole_pkg::POS_W+1)'(i_position) <=
                       (ole_pkg::POS_W+1)'(r_count) + (ole_pkg::POS_W+1)'(1));

    always_comb begin
        do_ins       = 1'b0;
        do_rem_front = 1'b0;
        ins_idx      = '0;
        n_status     = ole_pkg::ST_OK;
        n_found      = '0;
        n_count      = r_count;
        unique case (i_op)
            ole_pkg::OP_INS_FRONT, ole_pkg::OP_INS_BACK: begin
                ins_idx = (i_op == ole_pkg::OP_INS_FRONT) ? '0 : r_count;
                if (is_full) begin
                    n_status = ole_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + ole_pkg::COUNT_W'(1);
                end
            end
            ole_pkg::OP_INS_POS: begin
                ins_idx = ole_pkg::COUNT_W'(i_position - ole_pkg::POS_W'(1));
                if (is_full) begin
                    n_status = ole_pkg::ST_FULL;
                end else if (!pos_ok) begin
                    n_status = ole_pkg::ST_BADPOS;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + ole_pkg::COUNT_W'(1);
                end
            end
            ole_pkg::OP_REM_FRONT, ole_pkg::OP_REM_BACK: begin
                if (is_empty) begin
                    n_status = ole_pkg::ST_EMPTY;
                end else begin
                    // Removing the last entry needs no shift, only a shorter count.
                    do_rem_front = (i_op == ole_pkg::OP_REM_FRONT);
                    n_count      = r_count - ole_pkg::COUNT_W'(1);
                end
            end
            ole_pkg::OP_SEARCH: begin
                if (any_match) begin
                    n_found = ole_pkg::POS_W'(match_idx) + ole_pkg::POS_W'(1);
                end else begin
                    n_status = ole_pkg::ST_NOTFOUND;
                end
            end
            default: ;
        endcase
    end

    for (genvar j = 0; j < ole_pkg::CAPACITY; j++) begin : g_cell
        logic [ole_pkg::DATA_W-1:0] left_val;
        logic [ole_pkg::DATA_W-1:0] right_val;

        if (j == 0) begin : g_first
            assign left_val = i_value;
        end else begin : g_mid
            assign left_val = cell_val[j-1];
        end
        if (j == ole_pkg::CAPACITY - 1) begin : g_last
            assign right_val = cell_val[j];
        end else begin : g_inner
            assign right_val = cell_val[j+1];
        end

        always_comb begin
            cell_ctl[j].live = (ole_pkg::COUNT_W'(j) < r_count);
            cell_ctl[j].op   = ole_pkg::CELL_HOLD;
            if (acc && do_ins) begin
                if (ole_pkg::COUNT_W'(j) == ins_idx) begin
                    cell_ctl[j].op = ole_pkg::CELL_LOAD;
                end else if (ole_pkg::COUNT_W'(j) > ins_idx) begin
                    cell_ctl[j].op = ole_pkg::CELL_FROM_LEFT;
                end
            end else if (acc && do_rem_front) begin
                cell_ctl[j].op = ole_pkg::CELL_FROM_RIGHT;
            end
        end

        ole_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[j]),
            .i_new   (i_value),
            .i_left  (left_val),
            .i_right (right_val),
            .i_key   (i_value),
            .o_value (cell_val[j]),
            .o_match (match[j])
        );
    end

    ole_first_match u_first_match (
        .i_match (match),
        .o_any   (any_match),
        .o_index (match_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (acc) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status    <= n_status;
            r_found     <= n_found;
            r_count_out <= ole_pkg::POS_W'(n_count);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_count          = r_count_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ole_pkg::COUNT_W'(ole_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count == ole_pkg::POS_W'(r_count)))
        else $error("reported count differs from list count");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found_position != '0) |-> (o_status == ole_pkg::ST_OK))
        else $error("found position with non-ok status");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && is_full && (i_op == ole_pkg::OP_INS_FRONT || i_op == ole_pkg::OP_INS_BACK
         || i_op == ole_pkg::OP_INS_POS))
        |=> (r_count == ole_pkg::COUNT_W'(ole_pkg::CAPACITY)
             && o_status == ole_pkg::ST_FULL))
        else $error("insert into full list changed the count");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for ordered_list_engine: directed table plus random requests,
// checked against an in-bench model of the list. Depends on ole_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF_NS  = 6;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 870;
    localparam int MAX_IDLE     = 13;
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;
    // The timeout allows more than ten times the slowest correct run, with the
    // longest idle gaps on both sides and one long hold.
    localparam int TIMEOUT_NS   = 3_600_000;

    localparam logic [ole_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [ole_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam logic signed [ole_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ole_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        ole_pkg::t_status            status;
        logic [ole_pkg::POS_W-1:0]   found;
        logic [ole_pkg::POS_W-1:0]   count;
    } t_list_result;

    typedef struct packed {
        logic [ole_pkg::OP_W-1:0]          op;
        logic signed [ole_pkg::DATA_W-1:0] value;
        logic [ole_pkg::POS_W-1:0]         position;
        int                                reps;
        bit                                rand_value;
        bit                                typed;
        ole_pkg::t_status                  exp_status;
        logic [ole_pkg::POS_W-1:0]         exp_found;
        logic [ole_pkg::POS_W-1:0]         exp_count;
    } t_request_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_ready;
    logic [ole_pkg::OP_W-1:0]          i_op;
    logic signed [ole_pkg::DATA_W-1:0] i_value;
    logic [ole_pkg::POS_W-1:0]         i_position;
    logic                              o_valid;
    logic                              i_ready;
    logic [ole_pkg::ST_W-1:0]          o_status;
    logic [ole_pkg::POS_W-1:0]         o_found_position;
    logic [ole_pkg::POS_W-1:0]         o_count;

    ordered_list_engine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_value          (i_value),
        .i_position       (i_position),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_count          (o_count)
    );

    // Directed rows. Rows with typed set carry their expected result; the fill row
    // inserts random values and is checked against the list model.
    t_request_row directed_rows [0:18] = '{
        '{ole_pkg::OP_REM_FRONT, 32'sd0,  5'd0,  1, 1'b0, 1'b1, ole_pkg::ST_EMPTY,    5'd0, 5'd0},
        '{ole_pkg::OP_REM_BACK,  32'sd0,  5'd0,  1, 1'b0, 1'b1, ole_pkg::ST_EMPTY,    5'd0, 5'd0},
        '{ole_pkg::OP_SEARCH,    32'sd0,  5'd0,  1, 1'b0, 1'b1, ole_pkg::ST_NOTFOUND, 5'd0, 5'd0},
        '{ole_pkg::OP_INS_POS,   32'sd5,  5'd0,  1, 1'b0, 1'b1, ole_pkg::ST_BADPOS,   5'd0, 5'd0},
        '{ole_pkg::OP_INS_POS,   32'sd5,  5'd2,  1, 1'b0, 1'b1, ole_pkg::ST_BADPOS,   5'd0, 5'd0},
        '{ole_pkg::OP_INS_FRONT, VAL_MAX, 5'd31, 1, 1'b0, 1'b1, ole_pkg::ST_OK,       5'd0, 5'd1},
        '{ole_pkg::OP_INS_BACK,  VAL_MIN, 5'd0,  1, 1'b0, 1'b1, ole_pkg::ST_OK,       5'd0, 5'd2},
        '{ole_pkg::OP_INS_POS,   -32'sd1, 5'd2,  1, 1'b0, 1'b1, ole_pkg::ST_OK,       5'd0, 5'd3},
        '{ole_pkg::OP_SEARCH,    VAL_MIN, 5'd0,  1, 1'b0, 1'b1, ole_pkg::ST_OK,       5'd3, 5'd3},
        '{ole_pkg::OP_SEARCH,    -32'sd1, 5'd31, 1, 1'b0, 1'b1, ole_pkg::ST_OK,       5'd2, 5'd3},
        '{OP_UNUSED_6,           -32'sd1, 5'd31, 1, 1'b0, 1'b1, ole_pkg::ST_OK,       5'd0, 5'd3},
        '{OP_UNUSED_7,           32'sd0,  5'd0,  1, 1'b0, 1'b1, ole_pkg::ST_OK,       5'd0, 5'd3},
        '{ole_pkg::OP_INS_POS,   32'sd7,  5'd31, 1, 1'b0, 1'b1, ole_pkg::ST_BADPOS,   5'd0, 5'd3},
        '{ole_pkg::OP_INS_POS,   32'sd9,  5'd4,  1, 1'b0, 1'b1, ole_pkg::ST_OK,       5'd0, 5'd4},
        '{ole_pkg::OP_INS_BACK,  32'sd0,  5'd0, 12, 1'b1, 1'b0, ole_pkg::ST_OK,       5'd0, 5'd0},
        '{ole_pkg::OP_INS_FRONT, 32'sd1,  5'd1,  1, 1'b0, 1'b1, ole_pkg::ST_FULL,     5'd0, 5'd16},
        '{ole_pkg::OP_INS_POS,   32'sd1,  5'd0,  1, 1'b0, 1'b1, ole_pkg::ST_FULL,     5'd0, 5'd16},
        '{ole_pkg::OP_SEARCH,    VAL_MAX, 5'd0,  1, 1'b0, 1'b1, ole_pkg::ST_OK,       5'd1, 5'd16},
        '{ole_pkg::OP_REM_BACK,  32'sd0,  5'd0,  1, 1'b0, 1'b1, ole_pkg::ST_OK,       5'd0, 5'd15}
    };

    // List model state.
    logic signed [ole_pkg::DATA_W-1:0] list_vals [0:ole_pkg::CAPACITY-1];
    int                                list_len;

    t_list_result expected_q [$];
    bit           drv_typed;
    t_list_result drv_exp;
    bit           send_quiet;
    bit           recv_quiet;
    logic         recv_ready;
    bit           hold_off;

    int failures;
    int items_accepted;
    int results_checked;
    int status_seen [0:4];
    int full_reached;

    assign i_ready = recv_ready && !hold_off;

    task automatic apply_request(input logic [ole_pkg::OP_W-1:0] op,
                                 input logic signed [ole_pkg::DATA_W-1:0] value,
                                 input logic [ole_pkg::POS_W-1:0] position,
                                 output t_list_result res);
        int  slot;
        int  k;
        bit  hit;
        res.status = ole_pkg::ST_OK;
        res.found  = '0;
        case (op)
            ole_pkg::OP_INS_FRONT, ole_pkg::OP_INS_BACK, ole_pkg::OP_INS_POS: begin
                // A full list wins over a bad position.
                if (list_len >= ole_pkg::CAPACITY) begin
                    res.status = ole_pkg::ST_FULL;
                end else if (op == ole_pkg::OP_INS_POS &&
                             (position == 0 || position > list_len + 1)) begin
                    res.status = ole_pkg::ST_BADPOS;
                end else begin
                    if (op == ole_pkg::OP_INS_FRONT)
                        slot = 0;
                    else if (op == ole_pkg::OP_INS_BACK)
                        slot = list_len;
                    else
                        slot = int'(position) - 1;
                    for (k = list_len; k > slot; k--)
                        list_vals[k] = list_vals[k-1];
                    list_vals[slot] = value;
                    list_len++;
                end
            end
            ole_pkg::OP_REM_FRONT, ole_pkg::OP_REM_BACK: begin
                if (list_len == 0) begin
                    res.status = ole_pkg::ST_EMPTY;
                end else begin
                    if (op == ole_pkg::OP_REM_FRONT)
                        for (k = 0; k + 1 < list_len; k++)
                            list_vals[k] = list_vals[k+1];
                    list_len--;
                end
            end
            ole_pkg::OP_SEARCH: begin
                res.status = ole_pkg::ST_NOTFOUND;
                hit = 1'b0;
                for (k = 0; k < list_len; k++) begin
                    if (!hit && list_vals[k] == value) begin
                        hit        = 1'b1;
                        res.status = ole_pkg::ST_OK;
                        res.found  = ole_pkg::POS_W'(k + 1);
                    end
                end
            end
            default: ;
        endcase
        res.count = ole_pkg::POS_W'(list_len);
    endtask

    function automatic logic [ole_pkg::OP_W-1:0] pick_op(input int bias);
        int r;
        int cut [0:5];
        r = $urandom_range(0, 99);
        case (bias)
            0:       cut = '{25, 50, 72, 80, 86, 97};  // filling
            1:       cut = '{8, 16, 24, 52, 80, 97};   // draining
            default: cut = '{15, 30, 45, 60, 75, 97};
        endcase
        if (r < cut[0]) return ole_pkg::OP_INS_FRONT;
        if (r < cut[1]) return ole_pkg::OP_INS_BACK;
        if (r < cut[2]) return ole_pkg::OP_INS_POS;
        if (r < cut[3]) return ole_pkg::OP_REM_FRONT;
        if (r < cut[4]) return ole_pkg::OP_REM_BACK;
        if (r < cut[5]) return ole_pkg::OP_SEARCH;
        return r[0] ? OP_UNUSED_6 : OP_UNUSED_7;
    endfunction

    task automatic make_random_request(input int bias,
                                       output logic [ole_pkg::OP_W-1:0] op,
                                       output logic signed [ole_pkg::DATA_W-1:0] value,
                                       output logic [ole_pkg::POS_W-1:0] position);
        int r;
        int len;
        len = list_len;
        op  = pick_op(bias);
        r   = $urandom_range(0, 9);
        // A narrow pool of values makes duplicates, so searches see several matches.
        if (r < 3) begin
            value = int'($urandom_range(0, 15)) - 8;
        end else if (r == 3) begin
            case ($urandom_range(0, 3))
                0:       value = VAL_MAX;
                1:       value = VAL_MIN;
                2:       value = '0;
                default: value = '1;
            endcase
        end else begin
            value = $urandom;
        end
        if (op == ole_pkg::OP_SEARCH && len > 0 && $urandom_range(0, 9) < 6)
            value = list_vals[$urandom_range(0, len - 1)];
        r = $urandom_range(0, 19);
        if (op != ole_pkg::OP_INS_POS || r >= 17)
            position = ole_pkg::POS_W'($urandom_range(0, 31));
        else if (r < 14)
            position = ole_pkg::POS_W'($urandom_range(1, len + 1));
        else if (r < 16)
            position = '0;
        else
            position = ole_pkg::POS_W'(len + 2);
    endtask

    task automatic send_request(input logic [ole_pkg::OP_W-1:0] op,
                                input logic signed [ole_pkg::DATA_W-1:0] value,
                                input logic [ole_pkg::POS_W-1:0] position,
                                input bit typed,
                                input t_list_result exp);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_value    <= value;
        i_position <= position;
        drv_typed  <= typed;
        drv_exp    <= exp;
        do @(posedge i_clk); while (!(i_valid && o_ready));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("tb_top failed");
        $finish;
    end

    // Checks each result against the oldest expectation, then records the
    // expectation for an item accepted at the same edge.
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        t_list_result model;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got.status = ole_pkg::t_status'(o_status);
                got.found  = o_found_position;
                got.count  = o_count;
                if (expected_q.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("%0t: result with no item pending: status %0d found %0d count %0d",
                                 $realtime, o_status, o_found_position, o_count);
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.count !== want.count) begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display("%0t: mismatch on result %0d: status %0d/%0d found %0d/%0d count %0d/%0d (expected/actual)",
                                     $realtime, results_checked, want.status, got.status,
                                     want.found, got.found, want.count, got.count);
                    end
                end
                results_checked++;
            end
            if (i_valid && o_ready) begin
                apply_request(i_op, i_value, i_position, model);
                expected_q.push_back(drv_typed ? drv_exp : model);
                status_seen[model.status]++;
                if (list_len == ole_pkg::CAPACITY)
                    full_reached++;
                items_accepted++;
            end
        end
    end

    // Receiver: random stall per result and quiet stretches.
    initial begin
        int  wait_cycles;
        recv_quiet  = 1'b0;
        recv_ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                recv_quiet = !recv_quiet;
            wait_cycles = recv_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (wait_cycles > 0) begin
                recv_ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            recv_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // One long hold-off on the result side that backs the block up into its input.
    initial begin
        hold_off = 1'b0;
        wait (results_checked >= HOLD_AFTER);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        int                                row;
        int                                rep;
        int                                left;
        int                                phase_len;
        int                                bias;
        logic [ole_pkg::OP_W-1:0]          op;
        logic signed [ole_pkg::DATA_W-1:0] value;
        logic [ole_pkg::POS_W-1:0]         position;
        t_list_result                      typed_exp;

        failures        = 0;
        items_accepted  = 0;
        results_checked = 0;
        full_reached    = 0;
        list_len        = 0;
        send_quiet      = 1'b0;
        foreach (status_seen[s])
            status_seen[s] = 0;

        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_op       <= ole_pkg::OP_INS_FRONT;
        i_value    <= '0;
        i_position <= '0;
        drv_typed  <= 1'b0;
        drv_exp    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < $size(directed_rows); row++) begin
            typed_exp.status = directed_rows[row].exp_status;
            typed_exp.found  = directed_rows[row].exp_found;
            typed_exp.count  = directed_rows[row].exp_count;
            for (rep = 0; rep < directed_rows[row].reps; rep++) begin
                value = directed_rows[row].rand_value ? $urandom : directed_rows[row].value;
                send_request(directed_rows[row].op, value, directed_rows[row].position,
                             directed_rows[row].typed, typed_exp);
            end
        end

        // Random part in phases that push the list toward full, toward empty, or
        // hold it in the middle.
        left = RANDOM_ITEMS;
        while (left > 0) begin
            phase_len  = $urandom_range(20, 60);
            bias       = $urandom_range(0, 2);
            send_quiet = ($urandom_range(0, 3) == 0);
            while (phase_len > 0 && left > 0) begin
                make_random_request(bias, op, value, position);
                send_request(op, value, position, 1'b0, '0);
                phase_len--;
                left--;
            end
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests and checked %0d results; list full %0d times.",
                 items_accepted, results_checked, full_reached);
        $display("Statuses: ok %0d, full %0d, empty %0d, bad position %0d, not found %0d.",
                 status_seen[ole_pkg::ST_OK], status_seen[ole_pkg::ST_FULL],
                 status_seen[ole_pkg::ST_EMPTY], status_seen[ole_pkg::ST_BADPOS],
                 status_seen[ole_pkg::ST_NOTFOUND]);
        if (failures == 0 && expected_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("Failures: %0d", failures);
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
